### rtl/core/ast_pkg.sv
package ast_pkg;

  localparam int unsigned NumBucketsDefault = 256;
  localparam int unsigned NumWaysDefault    = 4;

  // page number: address bits from 12 up
  localparam int unsigned PageLsb = 12;
  localparam int unsigned PageW   = 20;

  localparam logic [31:0] NoSize = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_RESIZE = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    req_e        req_type;
    logic [31:0] addr;
    logic [31:0] new_addr;
    logic [31:0] block_size;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] size_out;
  } rsp_t;

  // one slot of a bucket row
  typedef struct packed {
    logic        vld;
    logic [31:0] addr;
    logic [31:0] size;
  } way_t;

  localparam int unsigned WayW = $bits(way_t);

endpackage

### rtl/core/ast_ram.sv
module ast_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ast_hash.sv
module ast_hash #(
  parameter int unsigned Buckets = ast_pkg::NumBucketsDefault
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic [ast_pkg::PageW-1:0]                      page_i,
  output logic                                           valid_o,
  output logic [((Buckets > 1) ? $clog2(Buckets) : 1)-1:0] bucket_o
);
  import ast_pkg::*;

  localparam int unsigned BW    = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam bit          IsPow2 = ((Buckets & (Buckets - 1)) == 0);

  if (IsPow2) begin : g_mask
    logic          done_q;
    logic [BW-1:0] bucket_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bucket_q <= page_i[BW-1:0] & BW'(Buckets - 1);
      end
    end

    assign valid_o  = done_q;
    assign bucket_o = bucket_q;
  end else begin : g_recip
    // quotient by reciprocal multiplication, exact for every page value;
    // the multiplier fits in PageW+1 bits for any count below 2**PageW
    localparam int unsigned      Shift   = PageW + BW;
    localparam logic [63:0]      MulFull = ((64'd1 << Shift) / 64'(Buckets)) + 64'd1;
    localparam logic [PageW:0]   Mul     = MulFull[PageW:0];

    logic                 stg1_q;
    logic                 stg2_q;
    logic                 done_q;
    logic [PageW-1:0]     page_q;
    logic [PageW-1:0]     quot_q;
    logic [BW-1:0]        rem_q;
    logic [2*PageW:0]     prod;
    logic [2*PageW-1:0]   back;

    assign prod = page_q * Mul;
    assign back = quot_q * PageW'(Buckets);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg1_q <= 1'b0;
        stg2_q <= 1'b0;
        done_q <= 1'b0;
      end else begin
        stg1_q <= start_i;
        stg2_q <= stg1_q;
        if (start_i) begin
          done_q <= 1'b0;
        end else if (stg2_q) begin
          done_q <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        page_q <= page_i;
      end
      if (stg1_q) begin
        quot_q <= PageW'(prod >> Shift);
      end
      if (stg2_q) begin
        rem_q <= BW'(page_q - back[PageW-1:0]);
      end
    end

    assign valid_o  = done_q;
    assign bucket_o = rem_q;
  end

endmodule

### rtl/core/allocation_size_table_core.sv
// Insert, lookup, remove and in-place resize: S_RD1 waits for the hash and reads
// the bucket row, S_EX1 compares, writes the row and registers the response. A
// moving resize drops the old entry in S_EX1, then inserts via S_RD2 and S_EX2.
// A new request is taken only in S_IDLE; a stalled response holds the response step.
// Non-power-of-two bucket counts hash by reciprocal multiply, multiply-subtract.
// Reset: a clearing pass writes every bucket row, one per cycle.
module allocation_size_table_core #(
  parameter int unsigned Buckets = ast_pkg::NumBucketsDefault,
  parameter int unsigned Ways    = ast_pkg::NumWaysDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ast_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output ast_pkg::rsp_t rsp_o
);
  import ast_pkg::*;

  localparam int unsigned BW   = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned RowW = Ways * WayW;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD1,
    S_EX1,
    S_RD2,
    S_EX2
  } state_e;

  state_e        state_q, state_d;
  req_t          req_q;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic [BW-1:0] clr_cnt_q;

  logic              accept;
  logic              hash_start;
  logic [PageW-1:0]  hash_page;
  logic              hash_valid;
  logic [BW-1:0]     hash_bucket;

  logic              ram_we, ram_re;
  logic [BW-1:0]     ram_waddr;
  logic [RowW-1:0]   ram_wdata, ram_rdata;

  way_t [Ways-1:0] row, row_new;
  logic [31:0]     key;
  logic            hit_any, free_any;
  logic [Ways-1:0] hit_vec, free_sel;
  logic [31:0]     hit_size;
  logic            need_rsp, ex_go, out_free, is_move;
  status_e         ex_status;
  logic [31:0]     ex_size;

  assign accept   = req_valid_i && req_ready_o;
  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign is_move  = (req_q.req_type == REQ_RESIZE) && (req_q.addr != req_q.new_addr);

  assign hash_start = accept || ((state_q == S_EX1) && is_move && ex_go);
  assign hash_page  = accept ? req_i.addr[PageLsb +: PageW] : req_q.new_addr[PageLsb +: PageW];

  ast_hash #(
    .Buckets(Buckets)
  ) u_hash (
    .clk_i,
    .rst_ni,
    .start_i (hash_start),
    .page_i  (hash_page),
    .valid_o (hash_valid),
    .bucket_o(hash_bucket)
  );

  ast_ram #(
    .Width(RowW),
    .Depth(Buckets)
  ) u_ram (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(hash_bucket),
    .rdata_o(ram_rdata)
  );

  // bucket compare: one match at most, lowest free way for a fill
  always_comb begin
    row      = ram_rdata;
    key      = (state_q == S_EX2) ? req_q.new_addr : req_q.addr;
    hit_vec  = '0;
    free_sel = '0;
    hit_size = '0;
    free_any = 1'b0;
    for (int w = 0; w < Ways; w++) begin
      hit_vec[w] = row[w].vld && (row[w].addr == key);
      if (hit_vec[w]) begin
        hit_size = hit_size | row[w].size;
      end
      if (!row[w].vld && !free_any) begin
        free_sel[w] = 1'b1;
        free_any    = 1'b1;
      end
    end
    hit_any = |hit_vec;
  end

  always_comb begin
    row_new   = row;
    ex_status = ST_OK;
    ex_size   = NoSize;
    need_rsp  = 1'b1;
    if ((state_q == S_EX2) || (req_q.req_type == REQ_INSERT)) begin
      if (hit_any) begin
        ex_status = ST_PRESENT;
      end else if (free_any) begin
        for (int w = 0; w < Ways; w++) begin
          if (free_sel[w]) begin
            row_new[w] = '{vld: 1'b1, addr: key, size: req_q.block_size};
          end
        end
      end else begin
        ex_status = ST_FULL;
      end
    end else begin
      unique case (req_q.req_type)
        REQ_LOOKUP: begin
          if (hit_any) begin
            ex_size = hit_size;
          end else begin
            ex_status = ST_MISSING;
          end
        end
        REQ_RESIZE: begin
          if (is_move) begin
            // drop the old entry, miss ignored; insert follows
            need_rsp = 1'b0;
            for (int w = 0; w < Ways; w++) begin
              if (hit_vec[w]) begin
                row_new[w].vld = 1'b0;
              end
            end
          end else if (hit_any) begin
            for (int w = 0; w < Ways; w++) begin
              if (hit_vec[w]) begin
                row_new[w].size = req_q.block_size;
              end
            end
          end else begin
            ex_status = ST_MISSING;
          end
        end
        REQ_REMOVE: begin
          if (hit_any) begin
            for (int w = 0; w < Ways; w++) begin
              if (hit_vec[w]) begin
                row_new[w].vld = 1'b0;
              end
            end
          end else begin
            ex_status = ST_MISSING;
          end
        end
        default: begin
          ex_status = ST_OK;
        end
      endcase
    end
    ex_go = !need_rsp || out_free;
  end

  always_comb begin
    state_d     = state_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = hash_bucket;
    ram_wdata   = RowW'(row_new);
    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == BW'(Buckets - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_RD1;
        end
      end
      S_RD1, S_RD2: begin
        if (hash_valid) begin
          ram_re  = 1'b1;
          state_d = (state_q == S_RD1) ? S_EX1 : S_EX2;
        end
      end
      S_EX1, S_EX2: begin
        // hold the read row until the response slot frees up
        if (ex_go) begin
          ram_we = 1'b1;
          if ((state_q == S_EX1) && is_move) begin
            state_d = S_RD2;
          end else begin
            state_d     = S_IDLE;
            rsp_d       = '{status: ex_status, size_out: ex_size};
            rsp_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      rsp_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
